>>> src/assert_macros.svh
// Assertion macros for the checker file.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
	else $error(msg);

`endif

>>> src/lcdseq_pkg.sv
// Shared types, codes and phase tables of the character LCD bus sequencer.
// No dependencies.
`default_nettype none

package lcdseq_pkg;

	// Input opcodes
	localparam logic [1:0] OP_DATA = 2'd0;
	localparam logic [1:0] OP_CMD  = 2'd1;
	localparam logic [1:0] OP_INIT = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_FOUR_BIT = 2'd0;
	localparam logic [1:0] REG_PULSE    = 2'd1;
	localparam logic [1:0] REG_POWER_UP = 2'd2;

	localparam logic        RST_FOUR_BIT = 1'b1;
	localparam logic [15:0] RST_PULSE    = 16'd1000;
	localparam logic [23:0] RST_POWER_UP = 24'd50000;

	// Init commands
	localparam logic [7:0] CMD_FUNC_8BIT  = 8'h38;
	localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
	localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] CMD_CLEAR      = 8'h01;
	localparam logic [7:0] NIBBLE_FUNC    = 8'h20;

	// Hold time selects
	localparam logic [1:0] HOLD_PULSE  = 2'd0;
	localparam logic [1:0] HOLD_DOUBLE = 2'd1;
	localparam logic [1:0] HOLD_WAIT   = 2'd2;

	localparam int STEP_W      = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] value;
	} job_t;

	typedef struct packed {
		logic        four_bit;
		logic [15:0] pulse;
		logic [23:0] power_up;
	} cfg_t;

	typedef struct packed {
		logic       empty;
		logic       full;
	} q_status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       en;
		logic [1:0] hold_sel;
		logic       last;
	} phase_t;

	function automatic phase_t mk_phase(logic [7:0] data, logic en, logic [1:0] sel,
			logic last);
		phase_t p;
		p.data     = data;
		p.en       = en;
		p.hold_sel = sel;
		p.last     = last;
		return p;
	endfunction

	// One byte as E strobes; extra stretches the closing E-low by one pulse.
	function automatic phase_t byte_phase(logic four_bit, logic [STEP_W-1:0] step,
			logic [7:0] value, logic extra);
		logic [7:0] hi;
		logic [7:0] lo;
		logic [1:0] tail;
		hi   = {value[7:4], 4'h0};
		lo   = {value[3:0], 4'h0};
		tail = extra ? HOLD_DOUBLE : HOLD_PULSE;
		if (four_bit) begin
			case (step[1:0])
				2'd0:    return mk_phase(hi, 1'b1, HOLD_PULSE, 1'b0);
				2'd1:    return mk_phase(hi, 1'b0, HOLD_PULSE, 1'b0);
				2'd2:    return mk_phase(lo, 1'b1, HOLD_PULSE, 1'b0);
				default: return mk_phase(lo, 1'b0, tail, 1'b1);
			endcase
		end else begin
			if (!step[0])
				return mk_phase(value, 1'b1, HOLD_PULSE, 1'b0);
			else
				return mk_phase(value, 1'b0, tail, 1'b1);
		end
	endfunction

	// Power-up wait, function set, display on, clear.
	function automatic phase_t init_phase(logic four_bit, logic [STEP_W-1:0] step);
		phase_t p;
		p = mk_phase(8'h00, 1'b0, HOLD_WAIT, 1'b0);
		if (four_bit) begin
			case (step) inside
				[4'd1:4'd2]:   p = mk_phase(NIBBLE_FUNC, ~step[1], HOLD_PULSE, 1'b0);
				[4'd3:4'd6]:   p = byte_phase(1'b1, step - 4'd3, CMD_FUNC_4BIT, 1'b1);
				[4'd7:4'd10]:  p = byte_phase(1'b1, step - 4'd7, CMD_DISPLAY_ON, 1'b1);
				[4'd11:4'd15]: p = byte_phase(1'b1, step - 4'd11, CMD_CLEAR, 1'b0);
				default:       p = mk_phase(8'h00, 1'b0, HOLD_WAIT, 1'b0);
			endcase
			if (step < 4'd11)
				p.last = 1'b0;
		end else begin
			case (step) inside
				[4'd1:4'd2]:  p = byte_phase(1'b0, step - 4'd1, CMD_FUNC_8BIT, 1'b1);
				[4'd3:4'd4]:  p = byte_phase(1'b0, step - 4'd3, CMD_DISPLAY_ON, 1'b1);
				[4'd5:4'd15]: p = byte_phase(1'b0, step - 4'd5, CMD_CLEAR, 1'b0);
				default:      p = mk_phase(8'h00, 1'b0, HOLD_WAIT, 1'b0);
			endcase
			if (step < 4'd5)
				p.last = 1'b0;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

>>> src/lcdseq_ifs.sv
// Valid/ready channel interfaces: requests in, bus phases out.
// No dependencies.
`default_nettype none

interface lcdseq_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
	modport monitor (input valid, input opcode, input value, input ready);
endinterface

interface lcdseq_out_if;
	logic        valid;
	logic        ready;
	logic        reg_select;
	logic        read_write;
	logic [7:0]  bus_data;
	logic        enable;
	logic [23:0] hold_ticks;
	logic        last_phase;

	modport source (output valid, output reg_select, output read_write, output bus_data,
		output enable, output hold_ticks, output last_phase, input ready);
	modport sink (input valid, input reg_select, input read_write, input bus_data,
		input enable, input hold_ticks, input last_phase, output ready);
	modport monitor (input valid, input reg_select, input read_write, input bus_data,
		input enable, input hold_ticks, input last_phase, input ready);
endinterface

`default_nettype wire

>>> src/lcdseq_front.sv
// Front end: takes request transfers, decodes them into jobs, pushes to the queue.
// Depends on lcdseq_pkg and lcdseq_in_if.
`default_nettype none

module lcdseq_front
	import lcdseq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	lcdseq_in_if.sink      cmd,
	input  wire q_status_t q_stat,
	output logic           push,
	output job_t           push_job
);

	logic valid_s1;
	job_t job_s1;
	logic accept;
	logic keep;
	job_t decoded;

	assign push      = valid_s1 && !q_stat.full;
	assign push_job  = job_s1;
	assign cmd.ready = !valid_s1 || !q_stat.full;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		decoded.value   = cmd.value;
		decoded.rs      = 1'b0;
		decoded.is_init = 1'b0;
		keep            = 1'b1;
		case (cmd.opcode)
			OP_DATA: decoded.rs      = 1'b1;
			OP_CMD:  decoded.rs      = 1'b0;
			OP_INIT: decoded.is_init = 1'b1;
			default: keep            = 1'b0; // unused opcode: dropped
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			job_s1 <= decoded;
	end

endmodule

`default_nettype wire

>>> src/lcdseq_queue.sv
// Short job queue between the front end and the phase generator.
// Depends on lcdseq_pkg.
`default_nettype none

module lcdseq_queue
	import lcdseq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_status_t stat
);

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

>>> src/lcdseq_back.sv
// Back end: steps through the phases of one job, one phase per output transfer.
// Depends on lcdseq_pkg and lcdseq_out_if.
`default_nettype none

module lcdseq_back
	import lcdseq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire q_status_t q_stat,
	input  wire job_t      q_job,
	output logic           pop,
	lcdseq_out_if.source   phase
);

	logic              active_q;
	job_t              job_q;
	logic [STEP_W-1:0] step_q;
	logic              ovalid_q;
	logic              rs_q;
	logic [7:0]        data_q;
	logic              en_q;
	logic [23:0]       hold_q;
	logic              last_q;

	phase_t      cur;
	logic        advance;
	logic [15:0] eff_pulse;
	logic [23:0] eff_wait;
	logic [23:0] hold;

	assign eff_pulse = (cfg.pulse == '0) ? 16'd1 : cfg.pulse;
	assign eff_wait  = (cfg.power_up == '0) ? 24'd1 : cfg.power_up;

	assign cur = job_q.is_init ? init_phase(cfg.four_bit, step_q)
		: byte_phase(cfg.four_bit, step_q, job_q.value, 1'b0);

	always_comb begin
		case (cur.hold_sel)
			HOLD_PULSE:  hold = {8'h00, eff_pulse};
			HOLD_DOUBLE: hold = {7'h00, eff_pulse, 1'b0};
			HOLD_WAIT:   hold = eff_wait;
			default:     hold = {8'h00, eff_pulse};
		endcase
	end

	// output register free or emptying this cycle
	assign advance = active_q && (!ovalid_q || phase.ready);
	assign pop     = !q_stat.empty && (!active_q || (advance && cur.last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (advance) begin
				if (cur.last)
					active_q <= 1'b0;
				else
					step_q <= step_q + 1'b1;
			end
			if (pop) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end
			if (advance)
				ovalid_q <= 1'b1;
			else if (phase.ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= q_job;
		if (advance) begin
			rs_q   <= job_q.is_init ? 1'b0 : job_q.rs;
			data_q <= cur.data;
			en_q   <= cur.en;
			hold_q <= hold;
			last_q <= cur.last;
		end
	end

	assign phase.valid      = ovalid_q;
	assign phase.reg_select = rs_q;
	assign phase.read_write = 1'b0;
	assign phase.bus_data   = data_q;
	assign phase.enable     = en_q;
	assign phase.hold_ticks = hold_q;
	assign phase.last_phase = last_q;

endmodule

`default_nettype wire

>>> src/char_lcd_bus_sequencer_top.sv
// Character LCD bus sequencer, top level: config registers, front end, queue, back end.
// The first phase of an item passes the decode register, a queue entry, the back-end
// job register and the output register. Throughput: one phase per cycle while the sink
// is ready and jobs are queued; the phase generator gives 2 or 4 phases per byte, 7 or 15 for init.
// Reset (arst_n low, asynchronous): queue and outputs empty, four_bit_mode=1,
// pulse_ticks=1000, power_up_ticks=50000.
`default_nettype none

module char_lcd_bus_sequencer_top
	import lcdseq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	// request channel: opcode, value
	lcdseq_in_if.sink        cmd,
	// bus phase channel
	lcdseq_out_if.source     phase
);

	cfg_t      cfg_q;
	q_status_t q_stat;
	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      head;

	// Config registers, read live by the back end. User rule, unenforced: written only while the block is idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit <= RST_FOUR_BIT;
			cfg_q.pulse    <= RST_PULSE;
			cfg_q.power_up <= RST_POWER_UP;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOUR_BIT: cfg_q.four_bit <= cfg_data[0];
				REG_PULSE:    cfg_q.pulse    <= cfg_data[15:0];
				REG_POWER_UP: cfg_q.power_up <= cfg_data;
				default:      ; // unknown index: ignored
			endcase
		end
	end

	// Front end: one request transfer per cycle into a decode register, while it is free or the queue has room.
	// Unused opcodes are dropped here and never reach the queue.
	lcdseq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	// Two-deep job queue decouples request stalls from bus phase stalls.
	lcdseq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	// Back end: phase step counter and output register. The next job is
	// popped in the cycle the last phase of the current one is registered,
	// so phases of consecutive items follow without a gap.
	lcdseq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.q_job  (head),
		.pop    (pop),
		.phase  (phase)
	);

endmodule

`default_nettype wire

>>> src/lcdseq_checker.sv
// Port-level checks on the bus phase channel of the sequencer top.
// Depends on assert_macros.svh; bound to char_lcd_bus_sequencer_top.
`default_nettype none
`include "assert_macros.svh"

module lcdseq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic        rw,
	input wire logic [7:0]  data,
	input wire logic        en,
	input wire logic [23:0] hold,
	input wire logic        last
);

	// stalled phase holds
	`ASSERT_CLK(a_stall_hold, valid && !ready |=> valid && $stable({data, hold, last}), "stall not held")

	// an E-high phase never closes an item
	`ASSERT_CLK(a_high_not_last, valid && en |-> !last, "item ended with E high")

	// write-only bus with nonzero hold
	`ASSERT_CLK(a_write_hold, valid |-> !rw && (hold != 24'd0), "bad RW or zero hold")

	// nothing offered right after reset
	`ASSERT_CLK_ALWAYS(a_reset_quiet, !arst_n |=> !valid, "phase valid out of reset")

endmodule

bind char_lcd_bus_sequencer_top lcdseq_checker u_lcdseq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.valid  (phase.valid),
	.ready  (phase.ready),
	.rw     (phase.read_write),
	.data   (phase.bus_data),
	.en     (phase.enable),
	.hold   (phase.hold_ticks),
	.last   (phase.last_phase)
);

`default_nettype wire

>>> test/char_lcd_bus_sequencer_top_tb.sv
// Testbench for char_lcd_bus_sequencer_top: LCD requests go in, and each bus phase that comes out
// is checked against a phase list built inside the bench.
// Depends on lcdseq_pkg (src/lcdseq_pkg.sv) and the channel interfaces (src/lcdseq_ifs.sv).

module char_lcd_bus_sequencer_top_tb;
	import lcdseq_pkg::*;

	// Codes that the package does not name: the spare opcode and the spare register index
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int IDLE_PCT      = 38;     // chance in 100 that a side sits out a cycle
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PRINT_CAP     = 30;     // keeps a badly broken run from flooding the log

	// One bus phase, as it appears on the phase channel
	typedef struct packed {
		logic        rs;
		logic        rw;
		logic [7:0]  data;
		logic        en;
		logic [23:0] hold;
		logic        last;
	} bus_phase_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	lcdseq_in_if  cmd_ch ();
	lcdseq_out_if phase_ch ();

	char_lcd_bus_sequencer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.phase     (phase_ch)
	);

	// Bench copy of the configuration registers, updated on each write edge
	logic        lcd_four_bit;
	logic [15:0] lcd_pulse;
	logic [23:0] lcd_power_up;

	// Bus phases still owed by the block, oldest first
	bus_phase_t lcd_phases[$];

	bit no_stall;
	int error_count;
	int item_count;
	int init_count;
	int phase_count;
	int cfg_count;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Runaway guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d phases still owed", cycle_count,
				lcd_phases.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Sink side: random back-pressure, none while no_stall is set
	always @(posedge clk)
		phase_ch.ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);

	task automatic report_mismatch(input string what, input logic [23:0] got_v,
			input logic [23:0] want_v);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("MISMATCH phase %0d %s: got 0x%0h, expected 0x%0h", phase_count, what,
				got_v, want_v);
	endtask

	// ---------------------------------------------------------------------
	// Phase list builder. The hold of an E phase is one pulse, where a pulse
	// register of zero counts as one tick.
	// ---------------------------------------------------------------------
	function automatic logic [23:0] pulse_hold();
		return (lcd_pulse == 16'd0) ? 24'd1 : {8'h00, lcd_pulse};
	endfunction

	function automatic void push_phase(logic rs, logic [7:0] data, logic en,
			logic [23:0] hold);
		bus_phase_t p;
		p.rs   = rs;
		p.rw   = 1'b0;
		p.data = data;
		p.en   = en;
		p.hold = hold;
		p.last = 1'b0;
		lcd_phases.push_back(p);
	endfunction

	// E high for one pulse, then E low for low_hold
	function automatic void push_strobe(logic rs, logic [7:0] data, logic [23:0] low_hold);
		push_phase(rs, data, 1'b1, pulse_hold());
		push_phase(rs, data, 1'b0, low_hold);
	endfunction

	// One byte; settle stretches the closing E-low by one more pulse
	function automatic void push_byte(logic rs, logic [7:0] b, logic settle);
		logic [23:0] p;
		logic [23:0] tail;
		p    = pulse_hold();
		tail = settle ? (p << 1) : p;
		if (lcd_four_bit) begin
			push_strobe(rs, {b[7:4], 4'h0}, p);
			push_strobe(rs, {b[3:0], 4'h0}, tail);
		end else begin
			push_strobe(rs, b, tail);
		end
	endfunction

	// All phases that one request causes, appended to lcd_phases
	function automatic void build_bus_phases(logic [1:0] op, logic [7:0] val);
		bus_phase_t closing;
		case (op)
			OP_DATA: push_byte(1'b1, val, 1'b0);
			OP_CMD:  push_byte(1'b0, val, 1'b0);
			OP_INIT: begin
				// power-up wait, zero counts as one tick
				push_phase(1'b0, 8'h00, 1'b0,
					(lcd_power_up == 24'd0) ? 24'd1 : lcd_power_up);
				if (lcd_four_bit) begin
					push_strobe(1'b0, NIBBLE_FUNC, pulse_hold());
					push_byte(1'b0, CMD_FUNC_4BIT, 1'b1);
				end else begin
					push_byte(1'b0, CMD_FUNC_8BIT, 1'b1);
				end
				push_byte(1'b0, CMD_DISPLAY_ON, 1'b1);
				push_byte(1'b0, CMD_CLEAR, 1'b0);
			end
			default: return;  // spare opcode: no phases at all
		endcase
		closing = lcd_phases.pop_back();
		closing.last = 1'b1;
		lcd_phases.push_back(closing);
	endfunction

	// ---------------------------------------------------------------------
	// Phase checker: every transfer on the phase channel is matched, field
	// by field, against the oldest owed phase.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_phase
		bus_phase_t got;
		bus_phase_t want;
		if (arst_n && phase_ch.valid && phase_ch.ready) begin
			got.rs   = phase_ch.reg_select;
			got.rw   = phase_ch.read_write;
			got.data = phase_ch.bus_data;
			got.en   = phase_ch.enable;
			got.hold = phase_ch.hold_ticks;
			got.last = phase_ch.last_phase;
			phase_count++;
			if (lcd_phases.size() == 0) begin
				report_mismatch("phase with none owed, bus_data", 24'(got.data), 24'h0);
			end else begin
				want = lcd_phases.pop_front();
				if (got.rs !== want.rs)
					report_mismatch("reg_select", 24'(got.rs), 24'(want.rs));
				if (got.rw !== want.rw)
					report_mismatch("read_write", 24'(got.rw), 24'(want.rw));
				if (got.data !== want.data)
					report_mismatch("bus_data", 24'(got.data), 24'(want.data));
				if (got.en !== want.en)
					report_mismatch("enable", 24'(got.en), 24'(want.en));
				if (got.hold !== want.hold)
					report_mismatch("hold_ticks", got.hold, want.hold);
				if (got.last !== want.last)
					report_mismatch("last_phase", 24'(got.last), 24'(want.last));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Drivers. All called at a rising edge; each drives with nonblocking
	// assignments and returns at the edge of a transfer, or after a write has ended.
	// ---------------------------------------------------------------------

	// Register write; the bench copy follows at the write edge
	task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_FOUR_BIT: lcd_four_bit = data[0];
			REG_PULSE:    lcd_pulse    = data[15:0];
			REG_POWER_UP: lcd_power_up = data;
			default:      ;  // spare index writes nothing
		endcase
		cfg_count++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// One request transfer, with random idle cycles ahead of it
	task automatic send_request(input logic [1:0] op, input logic [7:0] val);
		while (!no_stall && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.opcode <= op;
		cmd_ch.value  <= val;
		do @(posedge clk); while (!cmd_ch.ready);
		build_bus_phases(op, val);
		if (op != OP_UNUSED)
			item_count++;
		if (op == OP_INIT)
			init_count++;
	endtask

	// Hold off until every owed phase has come out
	task automatic drain_phases();
		cmd_ch.valid <= 1'b0;
		while (lcd_phases.size() != 0)
			@(posedge clk);
	endtask

	// Drained, plus a margin for a spare-opcode request still in the pipe
	task automatic settle();
		drain_phases();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A random request: mostly data and commands, some inits, a few spare opcodes
	task automatic send_random_request(output logic [1:0] op);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 3)       op = OP_UNUSED;
		else if (pick < 48) op = OP_DATA;
		else if (pick < 85) op = OP_CMD;
		else                op = OP_INIT;
		send_request(op, 8'($urandom_range(0, 255)));
	endtask

	// New random setting of all registers; bits above each register's width are noise
	task automatic random_setting();
		logic [31:0] noise;
		logic [15:0] pulse;
		logic [23:0] wait_ticks;
		noise = $urandom;
		case ($urandom_range(0, 4))
			0:       pulse = 16'd0;
			1:       pulse = 16'd1;
			2:       pulse = 16'hFFFF;
			3:       pulse = 16'($urandom_range(2, 40));
			default: pulse = 16'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0:       wait_ticks = 24'd0;
			1:       wait_ticks = 24'd1;
			2:       wait_ticks = 24'hFFFFFF;
			3:       wait_ticks = 24'($urandom_range(2, 5000));
			default: wait_ticks = 24'($urandom);
		endcase
		write_reg(REG_FOUR_BIT, 24'($urandom));
		write_reg(REG_PULSE, {noise[7:0], pulse});
		write_reg(REG_POWER_UP, wait_ticks);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_UNUSED, noise[31:8]);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Reset values: 4-bit transfers, 1000-tick pulses, 50000-tick power-up wait
	task automatic test_reset_defaults();
		send_request(OP_DATA, 8'h00);
		send_request(OP_DATA, 8'hFF);
		send_request(OP_CMD, 8'hA5);
		send_request(OP_INIT, 8'h00);
		send_request(OP_UNUSED, 8'h3C);   // ignored, no phases
		settle();
	endtask

	// 8-bit transfers with the shortest holds
	task automatic test_eight_bit_mode();
		write_reg(REG_FOUR_BIT, 24'h000000);
		write_reg(REG_PULSE, 24'h000001);
		write_reg(REG_POWER_UP, 24'h000001);
		send_request(OP_DATA, 8'hFF);
		send_request(OP_CMD, 8'h00);
		send_request(OP_INIT, 8'h5A);
		send_request(OP_UNUSED, 8'hFF);
		send_request(OP_DATA, 8'h81);
		settle();
	endtask

	// Longest holds; the doubled settle hold of an init command exceeds 16 bits
	task automatic test_hold_extremes();
		write_reg(REG_FOUR_BIT, 24'hFFFFFF);
		write_reg(REG_PULSE, 24'hFFFFFF);
		write_reg(REG_POWER_UP, 24'hFFFFFF);
		send_request(OP_INIT, 8'hFF);
		send_request(OP_DATA, 8'h96);
		send_request(OP_CMD, 8'h69);
		settle();
		write_reg(REG_FOUR_BIT, 24'hFFFFFE);
		send_request(OP_INIT, 8'h00);
		settle();
	endtask

	// Zero holds count as one tick; a write to the spare index changes nothing
	task automatic test_zero_holds();
		write_reg(REG_PULSE, 24'hFF0000);
		write_reg(REG_POWER_UP, 24'h000000);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send_request(OP_INIT, 8'h00);
		settle();
		write_reg(REG_FOUR_BIT, 24'h000001);
		send_request(OP_INIT, 8'hFF);
		send_request(OP_CMD, 8'h0F);
		send_request(OP_DATA, 8'hF0);
		settle();
	endtask

	// Long stretch with neither side idling
	task automatic test_back_to_back();
		logic [1:0] op;
		int n;
		random_setting();
		no_stall = 1'b1;
		n = 0;
		while (n < 40) begin
			send_random_request(op);
			if (op != OP_UNUSED)
				n++;
		end
		drain_phases();
		no_stall = 1'b0;
		settle();
	endtask

	// Random traffic over several register settings; each setting pauses
	// mid-way, and now and then at random, until the bus has caught up
	task automatic test_random_traffic();
		logic [1:0] op;
		int n;
		repeat (6) begin
			random_setting();
			n = 0;
			while (n < 57) begin
				send_random_request(op);
				if (op != OP_UNUSED)
					n++;
				if (n == 20 || $urandom_range(0, 39) == 0)
					drain_phases();
			end
			settle();
		end
	endtask

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_FOUR_BIT;
		cfg_data       = 24'h0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.opcode  = OP_DATA;
		cmd_ch.value   = 8'h00;
		phase_ch.ready = 1'b0;
		no_stall       = 1'b0;
		lcd_four_bit   = RST_FOUR_BIT;
		lcd_pulse      = RST_PULSE;
		lcd_power_up   = RST_POWER_UP;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_eight_bit_mode();
		test_hold_extremes();
		test_zero_holds();
		test_back_to_back();
		test_random_traffic();
		settle();

		$display("Covered %0d requests (%0d inits) and %0d bus phases over %0d register writes",
			item_count, init_count, phase_count, cfg_count);
		$display("in both bus widths, zero and full-scale holds, with and without stalls");
		if (error_count == 0 && lcd_phases.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
